### design/stl_pkg.sv
// Shared types, character codes and constants for the s-expression token lexer.
// Used by stl_front, stl_back and sexpr_token_lexer_unit; depends on nothing else.
package stl_pkg;

    typedef enum logic [3:0] {
        C_OTHER,
        C_DIGIT,
        C_LPAR,
        C_RPAR,
        C_QUOTE,
        C_DOT,
        C_SIGN,
        C_SYM,
        C_EOF,
        C_SPACE,
        C_NL,
        C_SEMI
    } class_t;

    typedef enum logic [6:0] {
        S_START   = 7'b0000001,
        S_COMMENT = 7'b0000010,
        S_NUMBER  = 7'b0000100,
        S_SIGN    = 7'b0001000,
        S_DOTS    = 7'b0010000,
        S_SYMB    = 7'b0100000,
        S_UNEXP   = 7'b1000000
    } state_t;

    typedef enum logic [3:0] {
        K_LPAR    = 4'd0,
        K_RPAR    = 4'd1,
        K_QUOTE   = 4'd2,
        K_DOT     = 4'd3,
        K_SYMB    = 4'd4,
        K_INT     = 4'd5,
        K_EOF     = 4'd6,
        K_UNEXP   = 4'd7,
        K_COMMENT = 4'd8
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_DOTS  = 2'd1,
        ERR_RANGE = 2'd2
    } lit_err_t;

    // Control part of one queue record: a token ended by this byte and a
    // one-byte token, or a zero-length eof token, started and finished by the same byte.
    typedef struct packed {
        logic  fin_valid;
        kind_t fin_kind;
        logic  neg;
        logic  ovf;
        logic  second_valid;
        kind_t second_kind;
    } rec_ctrl_t;

    localparam logic [7:0] CHAR_EOF   = 8'h00;
    localparam logic [7:0] CHAR_NL    = 8'h0a;
    localparam logic [7:0] CHAR_SEMI  = 8'h3b;
    localparam logic [7:0] CHAR_QUOTE = 8'h27;
    localparam logic [7:0] CHAR_LPAR  = 8'h28;
    localparam logic [7:0] CHAR_RPAR  = 8'h29;
    localparam logic [7:0] CHAR_DOT   = 8'h2e;
    localparam logic [7:0] CHAR_PLUS  = 8'h2b;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;

    // Largest accumulator value that may still take one more decimal digit.
    localparam logic [63:0] ACC_LIMIT_HI = 64'd922337203685477580;
    localparam logic [63:0] ACC_LIMIT_LO = 64'd922337203685477579;

    localparam int QUEUE_DEPTH = 4;

    function automatic class_t classify(input logic [7:0] b);
        class_t c;
        c = C_OTHER;
        if (b inside {[8'h30:8'h39]}) begin
            c = C_DIGIT;
        end
        else if (b inside {[8'h61:8'h7a], [8'h41:8'h5a]}) begin
            c = C_SYM;
        end
        else begin
            case (b)
                CHAR_LPAR:  c = C_LPAR;
                CHAR_RPAR:  c = C_RPAR;
                CHAR_QUOTE: c = C_QUOTE;
                CHAR_DOT:   c = C_DOT;
                CHAR_EOF:   c = C_EOF;
                CHAR_NL:    c = C_NL;
                CHAR_SEMI:  c = C_SEMI;
                CHAR_PLUS, CHAR_MINUS: c = C_SIGN;
                8'h2a, 8'h2f, 8'h40, 8'h24, 8'h25, 8'h5e, 8'h26, 8'h5f, 8'h3d,
                8'h3c, 8'h3e, 8'h7e, 8'h3f, 8'h21, 8'h5b, 8'h5d, 8'h7b, 8'h7d:
                    c = C_SYM;
                8'h20, 8'h09, 8'h0c, 8'h0d, 8'h0b:
                    c = C_SPACE;
                default: c = C_OTHER;
            endcase
        end
        return c;
    endfunction

endpackage

### design/sexpr_token_lexer_unit.sv
// Top level of the s-expression token lexer: front end, record queue and back end.
// Depends on stl_pkg, stl_front, stl_queue and stl_back.
//
// One source byte is taken per clock while full is low; a byte that ends a token and is
// itself a parenthesis, quote or end-of-input marker gives two result transactions, and
// a four-entry record queue between the lexer state update and the output register
// absorbs such bursts. The lexer state, including the multiply-by-ten value accumulator,
// updates in the cycle a byte is accepted; its tokens pass through the record queue and
// the output register before they reach the result ports. Byte 0 ends the input with an
// eof token and does not advance the offset.
module sexpr_token_lexer_unit #(
    parameter int OFFSET_BITS = 32,
    parameter int LENGTH_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [7:0]             byte_in,
    output logic                   empty,
    input  logic                   pop,
    output logic [3:0]             token_kind,
    output logic [OFFSET_BITS-1:0] token_offset,
    output logic [LENGTH_BITS-1:0] token_length,
    output logic signed [63:0]     int_value,
    output logic [1:0]             literal_error,
    output logic                   last_of_run
);

    localparam int REC_BITS = $bits(stl_pkg::rec_ctrl_t) + 2 * OFFSET_BITS + 64;

    logic                   accept;
    logic                   rec_push;
    stl_pkg::rec_ctrl_t     rec_ctrl;
    logic [OFFSET_BITS-1:0] rec_start;
    logic [OFFSET_BITS-1:0] rec_pos;
    logic [63:0]            rec_acc;
    logic [REC_BITS-1:0]    q_wdata;
    logic [REC_BITS-1:0]    q_rdata;
    logic                   q_empty;
    logic                   q_pop;
    stl_pkg::rec_ctrl_t     head_ctrl;
    logic [OFFSET_BITS-1:0] head_start;
    logic [OFFSET_BITS-1:0] head_pos;
    logic [63:0]            head_acc;

    assign accept  = push && !full;
    assign q_wdata = {rec_ctrl, rec_start, rec_pos, rec_acc};
    assign {head_ctrl, head_start, head_pos, head_acc} = q_rdata;

    stl_front #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .byte_in  (byte_in),
        .rec_push (rec_push),
        .rec_ctrl (rec_ctrl),
        .rec_start(rec_start),
        .rec_pos  (rec_pos),
        .rec_acc  (rec_acc)
    );

    stl_queue #(
        .DATA_BITS(REC_BITS),
        .DEPTH    (stl_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk  (clk),
        .rst_n(rst_n),
        .push (rec_push),
        .wdata(q_wdata),
        .pop  (q_pop),
        .rdata(q_rdata),
        .full (full),
        .empty(q_empty)
    );

    stl_back #(
        .OFFSET_BITS(OFFSET_BITS),
        .LENGTH_BITS(LENGTH_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .head_ctrl    (head_ctrl),
        .head_start   (head_start),
        .head_pos     (head_pos),
        .head_acc     (head_acc),
        .pop          (pop),
        .empty        (empty),
        .token_kind   (token_kind),
        .token_offset (token_offset),
        .token_length (token_length),
        .int_value    (int_value),
        .literal_error(literal_error),
        .last_of_run  (last_of_run)
    );

    a_eof_makes_record: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (byte_in == stl_pkg::CHAR_EOF)) |-> rec_push)
        else $error("end-of-input byte produced no token record");

    a_record_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rec_push |-> (rec_ctrl.fin_valid || rec_ctrl.second_valid))
        else $error("token record carries no token");

    a_value_only_on_int: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (token_kind != stl_pkg::K_INT)) |-> (int_value == 64'sd0))
        else $error("non-integer token carries a value");

    a_range_error_on_int: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (literal_error == stl_pkg::ERR_RANGE)) |->
        ((token_kind == stl_pkg::K_INT) && (int_value == 64'sd0)))
        else $error("range error on a token that is not a zero-valued integer");

endmodule

### design/stl_front.sv
// Front end of the token lexer: classifies each byte and advances the lexer state.
// Emits one queue record per byte that finishes at least one token; uses stl_pkg.
module stl_front #(
    parameter int OFFSET_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic [7:0]             byte_in,
    output logic                   rec_push,
    output stl_pkg::rec_ctrl_t     rec_ctrl,
    output logic [OFFSET_BITS-1:0] rec_start,
    output logic [OFFSET_BITS-1:0] rec_pos,
    output logic [63:0]            rec_acc
);

    stl_pkg::state_t        state_reg, state_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [63:0]            acc_reg, acc_next;
    logic                   neg_reg, neg_next;
    logic                   ovf_reg, ovf_next;

    stl_pkg::class_t        cls;
    stl_pkg::state_t        cont_state;
    stl_pkg::kind_t         fin_kind;
    stl_pkg::kind_t         second_kind;
    logic                   fin_valid;
    logic                   second_valid;
    logic                   add_digit;
    logic                   restart;
    logic                   word_char;
    logic [63:0]            acc_limit;
    logic [63:0]            acc_mac;

    always_comb
    begin
        cls        = stl_pkg::classify(byte_in);
        word_char  = (cls == stl_pkg::C_SIGN) || (cls == stl_pkg::C_DOT) ||
                     (cls == stl_pkg::C_SYM) || (cls == stl_pkg::C_DIGIT);
        cont_state = state_reg;
        fin_valid  = 1'b0;
        fin_kind   = stl_pkg::K_SYMB;
        add_digit  = 1'b0;
        case (state_reg)
            stl_pkg::S_COMMENT:
            begin
                if ((cls == stl_pkg::C_EOF) || (cls == stl_pkg::C_NL)) begin
                    fin_valid = 1'b1;
                    fin_kind  = stl_pkg::K_COMMENT;
                end
            end
            stl_pkg::S_SIGN:
            begin
                if (cls == stl_pkg::C_DIGIT) begin
                    cont_state = stl_pkg::S_NUMBER;
                    add_digit  = 1'b1;
                end
                else if (word_char) begin
                    cont_state = stl_pkg::S_SYMB;
                end
                else begin
                    fin_valid = 1'b1;
                    fin_kind  = stl_pkg::K_SYMB;
                end
            end
            stl_pkg::S_NUMBER:
            begin
                if (cls == stl_pkg::C_DIGIT) begin
                    add_digit = 1'b1;
                end
                else if (word_char) begin
                    cont_state = stl_pkg::S_SYMB;
                end
                else begin
                    fin_valid = 1'b1;
                    fin_kind  = stl_pkg::K_INT;
                end
            end
            stl_pkg::S_DOTS:
            begin
                if (cls == stl_pkg::C_DOT) begin
                    cont_state = stl_pkg::S_DOTS;
                end
                else if (word_char) begin
                    cont_state = stl_pkg::S_SYMB;
                end
                else begin
                    fin_valid = 1'b1;
                    fin_kind  = stl_pkg::K_DOT;
                end
            end
            stl_pkg::S_SYMB:
            begin
                if (!word_char) begin
                    fin_valid = 1'b1;
                    fin_kind  = stl_pkg::K_SYMB;
                end
            end
            stl_pkg::S_UNEXP:
            begin
                if (cls != stl_pkg::C_OTHER) begin
                    fin_valid = 1'b1;
                    fin_kind  = stl_pkg::K_UNEXP;
                end
            end
            default:
            begin
                cont_state = stl_pkg::S_START;
            end
        endcase
        restart = fin_valid || (cont_state == stl_pkg::S_START);
    end

    always_comb
    begin
        acc_limit = ((byte_in[3:0] == 4'd9) || ((byte_in[3:0] == 4'd8) && !neg_reg)) ?
                    stl_pkg::ACC_LIMIT_LO : stl_pkg::ACC_LIMIT_HI;
        acc_mac   = {acc_reg[60:0], 3'b000} + {acc_reg[62:0], 1'b0} + 64'(byte_in[3:0]);
    end

    always_comb
    begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        start_next   = start_reg;
        acc_next     = acc_reg;
        neg_next     = neg_reg;
        ovf_next     = ovf_reg;
        second_valid = 1'b0;
        second_kind  = stl_pkg::K_EOF;
        if (accept) begin
            if (!restart) begin
                state_next = cont_state;
                pos_next   = pos_reg + OFFSET_BITS'(1);
                if (add_digit && !ovf_reg) begin
                    if (acc_reg > acc_limit) begin
                        ovf_next = 1'b1;
                    end
                    else begin
                        acc_next = acc_mac;
                    end
                end
            end
            else begin
                start_next = pos_reg;
                state_next = stl_pkg::S_START;
                pos_next   = (cls == stl_pkg::C_EOF) ? pos_reg : pos_reg + OFFSET_BITS'(1);
                case (cls)
                    stl_pkg::C_OTHER:
                        state_next = stl_pkg::S_UNEXP;
                    stl_pkg::C_DIGIT:
                    begin
                        state_next = stl_pkg::S_NUMBER;
                        neg_next   = 1'b0;
                        ovf_next   = 1'b0;
                        acc_next   = 64'(byte_in[3:0]);
                    end
                    stl_pkg::C_SIGN:
                    begin
                        state_next = stl_pkg::S_SIGN;
                        neg_next   = (byte_in == stl_pkg::CHAR_MINUS);
                        ovf_next   = 1'b0;
                        acc_next   = 64'd0;
                    end
                    stl_pkg::C_DOT:
                        state_next = stl_pkg::S_DOTS;
                    stl_pkg::C_SYM:
                        state_next = stl_pkg::S_SYMB;
                    stl_pkg::C_SEMI:
                        state_next = stl_pkg::S_COMMENT;
                    stl_pkg::C_LPAR:
                    begin
                        second_valid = 1'b1;
                        second_kind  = stl_pkg::K_LPAR;
                    end
                    stl_pkg::C_RPAR:
                    begin
                        second_valid = 1'b1;
                        second_kind  = stl_pkg::K_RPAR;
                    end
                    stl_pkg::C_QUOTE:
                    begin
                        second_valid = 1'b1;
                        second_kind  = stl_pkg::K_QUOTE;
                    end
                    stl_pkg::C_EOF:
                    begin
                        second_valid = 1'b1;
                        second_kind  = stl_pkg::K_EOF;
                    end
                    default:
                    begin
                        state_next = stl_pkg::S_START;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= stl_pkg::S_START;
            pos_reg   <= '0;
            start_reg <= '0;
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            acc_reg   <= acc_next;
            neg_reg   <= neg_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_comb
    begin
        rec_push              = accept && (fin_valid || second_valid);
        rec_ctrl.fin_valid    = fin_valid;
        rec_ctrl.fin_kind     = fin_kind;
        rec_ctrl.neg          = neg_reg;
        rec_ctrl.ovf          = ovf_reg;
        rec_ctrl.second_valid = second_valid;
        rec_ctrl.second_kind  = second_kind;
        rec_start             = start_reg;
        rec_pos               = pos_reg;
        rec_acc               = acc_reg;
    end

endmodule

### design/stl_queue.sv
// Small first-in first-out queue of token records between lexer front and back.
// Generic in record width and depth; no package dependency.
module stl_queue #(
    parameter int DATA_BITS = 8,
    parameter int DEPTH     = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic [DATA_BITS-1:0] wdata,
    input  logic                 pop,
    output logic [DATA_BITS-1:0] rdata,
    output logic                 full,
    output logic                 empty
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [PTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]  count_reg, count_next;
    logic                 do_push;
    logic                 do_pop;

    always_comb
    begin
        full        = (count_reg == CNT_BITS'(DEPTH));
        empty       = (count_reg == '0);
        do_push     = push && !full;
        do_pop      = pop && !empty;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_BITS'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_BITS'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_BITS'(1);
        end
        else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_BITS'(1);
        end
        rdata = mem[rd_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### design/stl_back.sv
// Back end of the token lexer: expands queue records into result transactions.
// Computes length, value and error of each token into an output register; uses stl_pkg.
module stl_back #(
    parameter int OFFSET_BITS = 32,
    parameter int LENGTH_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_empty,
    output logic                    q_pop,
    input  stl_pkg::rec_ctrl_t      head_ctrl,
    input  logic [OFFSET_BITS-1:0]  head_start,
    input  logic [OFFSET_BITS-1:0]  head_pos,
    input  logic [63:0]             head_acc,
    input  logic                    pop,
    output logic                    empty,
    output logic [3:0]              token_kind,
    output logic [OFFSET_BITS-1:0]  token_offset,
    output logic [LENGTH_BITS-1:0]  token_length,
    output logic signed [63:0]      int_value,
    output logic [1:0]              literal_error,
    output logic                    last_of_run
);

    localparam int LW = (OFFSET_BITS > LENGTH_BITS) ? OFFSET_BITS : LENGTH_BITS;
    localparam logic [LW-1:0] LEN_MAX = LW'({LENGTH_BITS{1'b1}});

    logic                   out_valid_reg, out_valid_next;
    logic                   phase_reg, phase_next;
    stl_pkg::kind_t         kind_reg, kind_sel;
    logic [OFFSET_BITS-1:0] offset_reg, offset_sel;
    logic [LENGTH_BITS-1:0] length_reg, length_sel;
    logic [63:0]            value_reg, value_sel;
    stl_pkg::lit_err_t      err_reg, err_sel;
    logic                   last_reg, last_sel;

    logic                   load;
    logic                   emit_first;
    logic [OFFSET_BITS-1:0] first_len;
    logic [LW-1:0]          first_len_ext;

    always_comb
    begin
        load          = !out_valid_reg || pop;
        emit_first    = head_ctrl.fin_valid && !phase_reg;
        first_len     = head_pos - head_start;
        first_len_ext = LW'(first_len);
        q_pop         = load && !q_empty && !(emit_first && head_ctrl.second_valid);

        if (emit_first) begin
            kind_sel   = head_ctrl.fin_kind;
            offset_sel = head_start;
            length_sel = (first_len_ext > LEN_MAX) ? LENGTH_BITS'(LEN_MAX) :
                         LENGTH_BITS'(first_len_ext);
            value_sel  = 64'd0;
            err_sel    = stl_pkg::ERR_NONE;
            last_sel   = !head_ctrl.second_valid;
            if (head_ctrl.fin_kind == stl_pkg::K_INT) begin
                if (head_ctrl.ovf) begin
                    err_sel = stl_pkg::ERR_RANGE;
                end
                else begin
                    value_sel = head_ctrl.neg ? 64'd0 - head_acc : head_acc;
                end
            end
            else if ((head_ctrl.fin_kind == stl_pkg::K_DOT) &&
                     (first_len != OFFSET_BITS'(1))) begin
                kind_sel = stl_pkg::K_SYMB;
                err_sel  = stl_pkg::ERR_DOTS;
            end
        end
        else begin
            kind_sel   = head_ctrl.second_kind;
            offset_sel = head_pos;
            length_sel = (head_ctrl.second_kind == stl_pkg::K_EOF) ? '0 : LENGTH_BITS'(1);
            value_sel  = 64'd0;
            err_sel    = stl_pkg::ERR_NONE;
            last_sel   = 1'b1;
        end

        out_valid_next = out_valid_reg;
        phase_next     = phase_reg;
        if (load) begin
            out_valid_next = !q_empty;
            if (!q_empty) begin
                phase_next = emit_first && head_ctrl.second_valid;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && !q_empty) begin
            kind_reg   <= kind_sel;
            offset_reg <= offset_sel;
            length_reg <= length_sel;
            value_reg  <= value_sel;
            err_reg    <= err_sel;
            last_reg   <= last_sel;
        end
    end

    always_comb
    begin
        empty         = !out_valid_reg;
        token_kind    = kind_reg;
        token_offset  = offset_reg;
        token_length  = length_reg;
        int_value     = value_reg;
        literal_error = err_reg;
        last_of_run   = last_reg;
    end

endmodule
